// ===== rtl/ggap_pkg.sv =====
// Package for the GGA fix-quality parser: character codes, sentence state
// type, its reset value and the small character classifiers.
// No dependencies.
package ggap_pkg;

    localparam logic [2:0] QUALITY_FIELD   = 3'd6;
    localparam logic [2:0] MAX_FIELD_CHARS = 3'd3;
    localparam logic [2:0] POS_SAT         = 3'd7;
    localparam logic [2:0] FIELD_SAT       = 3'd7;
    localparam logic [2:0] MIN_STAR_POS    = 3'd6;
    localparam logic [1:0] HEX_DIGITS      = 2'd2;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_A      = 8'h41;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_STOP   = 2'd2
    } num_phase_t;

    typedef enum logic [1:0] {
        Q_OPEN   = 2'd0,
        Q_READ   = 2'd1,
        Q_REJECT = 2'd2
    } quality_t;

    typedef struct packed {
        logic [2:0] byte_position;
        logic       start_ok;
        logic       type_ok;
        logic       star_seen;
        logic [1:0] bytes_after_star;
        logic [7:0] running_xor;
        logic [7:0] expected_sum;
        logic       hex_ok;
        logic [2:0] field_count;
        logic [2:0] field_length;
        num_phase_t number_phase;
        logic       number_negative;
        logic [9:0] number_value;
        quality_t   quality_done;
    } sentence_state_t;

    localparam sentence_state_t STATE_RESET = '{
        byte_position:    3'd0,
        start_ok:         1'b0,
        type_ok:          1'b0,
        star_seen:        1'b0,
        bytes_after_star: 2'd0,
        running_xor:      8'd0,
        expected_sum:     8'd0,
        hex_ok:           1'b1,
        field_count:      3'd0,
        field_length:     3'd0,
        number_phase:     PH_SKIP,
        number_negative:  1'b0,
        number_value:     10'd0,
        quality_done:     Q_OPEN
    };

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    // space, TAB, LF, VT, FF, CR
    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c inside {[8'h09:8'h0D]});
    endfunction

    // {valid, nibble}; either case accepted
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]})
            r = {1'b1, c[3:0]};
        else if ((c inside {[8'h41:8'h46]}) || (c inside {[8'h61:8'h66]}))
            r = {1'b1, c[3:0] + 4'd9};
        return r;
    endfunction

endpackage

// ===== rtl/ggap_step.sv =====
// Per-byte update of the sentence state and the result it gives on the
// final byte. Purely combinational. Depends on ggap_pkg.
module ggap_step
    import ggap_pkg::*;
#(
    parameter logic [2:0] QUAL_FIELD = QUALITY_FIELD,
    parameter logic [2:0] MAX_CHARS  = MAX_FIELD_CHARS
)
(
    input  sentence_state_t    st,
    input  logic [7:0]         char_in,
    input  logic               end_of_line,
    output sentence_state_t    st_next,
    output logic               fix_ok,
    output logic signed [10:0] fix_quality
);

    sentence_state_t n;
    logic            sep;
    logic            digit;
    logic [2:0]      len_inc;
    logic [4:0]      hex;
    num_phase_t      ph;
    logic [10:0]     mag;

    always_comb
    begin
        n       = st;
        sep     = 1'b0;
        digit   = is_digit(char_in);
        len_inc = st.field_length + 3'd1;
        hex     = hex_value(char_in);
        ph      = st.number_phase;

        if (!st.star_seen)
        begin
            if (st.byte_position == 3'd0)
            begin
                n.start_ok = (char_in == CH_DOLLAR);
            end
            else if (char_in == CH_STAR)
            begin
                n.star_seen = 1'b1;
                if (st.byte_position < MIN_STAR_POS)
                    n.type_ok = 1'b0;
            end
            else
            begin
                n.running_xor = st.running_xor ^ char_in;
                case (st.byte_position)
                    3'd3:    n.type_ok = (char_in == CH_G);
                    3'd4:    n.type_ok = st.type_ok && (char_in == CH_G);
                    3'd5:    n.type_ok = st.type_ok && (char_in == CH_A);
                    default: n.type_ok = st.type_ok;
                endcase
            end

            // the star closes the last field
            if (st.quality_done == Q_OPEN)
            begin
                sep = (char_in == CH_COMMA) || n.star_seen;
                if (st.field_count == QUAL_FIELD)
                begin
                    if (sep)
                    begin
                        n.quality_done = ((st.field_length == 3'd0) ||
                                          (st.field_length > MAX_CHARS))
                                         ? Q_REJECT : Q_READ;
                    end
                    else if (st.field_length <= MAX_CHARS)
                    begin
                        n.field_length = len_inc;
                        if (len_inc <= MAX_CHARS)
                        begin
                            // atoi: blanks, one sign, then digits
                            if (ph == PH_SKIP)
                            begin
                                if (is_blank(char_in))
                                    ph = PH_SKIP;
                                else if ((char_in == CH_PLUS) || (char_in == CH_MINUS))
                                begin
                                    n.number_negative = (char_in == CH_MINUS);
                                    n.number_phase    = PH_DIGITS;
                                end
                                else
                                begin
                                    ph = digit ? PH_DIGITS : PH_STOP;
                                    n.number_phase = ph;
                                end
                            end
                            else if (ph == PH_DIGITS)
                            begin
                                n.number_phase = ph;
                            end
                            if ((st.number_phase != PH_SKIP || !is_blank(char_in)) &&
                                !(st.number_phase == PH_SKIP &&
                                  ((char_in == CH_PLUS) || (char_in == CH_MINUS))) &&
                                (ph == PH_DIGITS))
                            begin
                                if (digit)
                                    n.number_value = (st.number_value << 3) +
                                                     (st.number_value << 1) +
                                                     {6'd0, char_in[3:0]};
                                else
                                    n.number_phase = PH_STOP;
                            end
                        end
                    end
                end
                else if (sep && (st.field_count < FIELD_SAT))
                begin
                    n.field_count = st.field_count + 3'd1;
                end
            end
        end
        else if (st.bytes_after_star < HEX_DIGITS)
        begin
            if (!hex[4])
                n.hex_ok = 1'b0;
            else
                n.expected_sum = {st.expected_sum[3:0], hex[3:0]};
            n.bytes_after_star = st.bytes_after_star + 2'd1;
        end

        if (st.byte_position < POS_SAT)
            n.byte_position = st.byte_position + 3'd1;

        fix_ok = n.start_ok && n.type_ok && n.star_seen &&
                 (n.bytes_after_star == HEX_DIGITS) && n.hex_ok &&
                 (n.running_xor == n.expected_sum) && (n.quality_done == Q_READ);
        mag = {1'b0, n.number_value};
        if (!fix_ok)
            fix_quality = 11'sd0;
        else if (n.number_negative)
            fix_quality = $signed(11'd0 - mag);
        else
            fix_quality = $signed(mag);

        st_next = end_of_line ? STATE_RESET : n;
    end

endmodule

// ===== rtl/nmea_gga_fix_quality_parser.sv =====
// Top level of the GGA fix-quality parser: input register, sentence state,
// result register. Depends on ggap_pkg and ggap_step.
//
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall  | char_in, end_of_line
// out     | output    | out_valid / out_stall| fix_ok, fix_quality
//
// One byte per cycle sustained while no final byte waits on a stalled result; a
// result is offered once the input register has taken the transaction carrying
// end_of_line and the result register has taken the step's output.
// Reset clears the sentence state and both valid flags.
// A final byte waits in the input register only while an unread result
// is stalled; other bytes always flow.
module nmea_gga_fix_quality_parser
    import ggap_pkg::*;
#(
    parameter logic [2:0] QUAL_FIELD = QUALITY_FIELD,
    parameter logic [2:0] MAX_CHARS  = MAX_FIELD_CHARS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         char_in,
    input  logic               end_of_line,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               fix_ok,
    output logic signed [10:0] fix_quality
);

    logic               in_valid_reg;
    logic [7:0]         char_reg;
    logic               eol_reg;
    sentence_state_t    state_reg;
    sentence_state_t    state_next;
    logic               out_valid_reg;
    logic               fix_ok_reg;
    logic signed [10:0] fix_quality_reg;
    logic               fix_ok_next;
    logic signed [10:0] fix_quality_next;
    logic               proceed;
    logic               in_take;

    ggap_step #(
        .QUAL_FIELD (QUAL_FIELD),
        .MAX_CHARS  (MAX_CHARS)
    ) u_step (
        .st          (state_reg),
        .char_in     (char_reg),
        .end_of_line (eol_reg),
        .st_next     (state_next),
        .fix_ok      (fix_ok_next),
        .fix_quality (fix_quality_next)
    );

    assign proceed  = in_valid_reg && (!eol_reg || !out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !proceed;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            state_reg     <= STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (proceed)
                in_valid_reg <= 1'b0;

            if (proceed)
                state_reg <= state_next;

            if (proceed && eol_reg)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            char_reg <= char_in;
            eol_reg  <= end_of_line;
        end
        if (proceed && eol_reg)
        begin
            fix_ok_reg      <= fix_ok_next;
            fix_quality_reg <= fix_quality_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign fix_ok      = fix_ok_reg;
    assign fix_quality = fix_quality_reg;

endmodule

// ===== rtl/ggap_checker.sv =====
// Port-level checks for the GGA fix-quality parser, bound to the top level.
// Depends on nmea_gga_fix_quality_parser.
module ggap_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic               fix_ok,
    input logic signed [10:0] fix_quality
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // input back-pressure only comes from a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !fix_ok |-> fix_quality == 11'sd0)
        else $error("invalid fix with non-zero quality");

    // three characters at most: -99 .. 999
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fix_ok |-> (fix_quality >= -11'sd99) && (fix_quality <= 11'sd999))
        else $error("quality out of range");

endmodule

bind nmea_gga_fix_quality_parser ggap_checker u_ggap_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .fix_ok      (fix_ok),
    .fix_quality (fix_quality)
);

// ===== bench/nmea_gga_fix_quality_parser_tb.sv =====
`timescale 1ns / 100ps
// Testbench for nmea_gga_fix_quality_parser: a byte-stream driver, a result
// monitor and a predictor of the sentence checks and the quality read-out.
// Depends on ggap_pkg and the parser RTL.
module nmea_gga_fix_quality_parser_tb
    import ggap_pkg::*;
;

    localparam int QUIET_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_UA   = 8'h41;
    localparam logic [7:0] CH_UF   = 8'h46;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LF_A = 8'h66;

    typedef struct packed {
        logic [7:0] ch;
        logic       eol;
    } char_item_t;

    typedef struct packed {
        logic               ok;
        logic signed [10:0] quality;
    } fix_result_t;

    // running picture of the sentence as the parser should see it
    typedef struct packed {
        logic [2:0] pos;
        logic       dollar_ok;
        logic       gga_ok;
        logic       star;
        logic [1:0] hex_cnt;
        logic [7:0] xsum;
        logic [7:0] given_sum;
        logic       hex_good;
        logic [2:0] fld;
        logic [2:0] flen;
        num_phase_t ph;
        logic       neg;
        logic [9:0] val;
        quality_t   qstate;
    } gga_track_t;

    localparam gga_track_t TRACK_CLEAR = '{
        pos:       3'd0,
        dollar_ok: 1'b0,
        gga_ok:    1'b0,
        star:      1'b0,
        hex_cnt:   2'd0,
        xsum:      8'd0,
        given_sum: 8'd0,
        hex_good:  1'b1,
        fld:       3'd0,
        flen:      3'd0,
        ph:        PH_SKIP,
        neg:       1'b0,
        val:       10'd0,
        qstate:    Q_OPEN
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         char_in = 8'h00;
    logic               end_of_line = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               fix_ok;
    logic signed [10:0] fix_quality;

    char_item_t  pending_bytes[$];
    fix_result_t expected_fixes[$];
    logic [7:0]  draft[$];
    char_item_t  next_item;
    fix_result_t want;
    gga_track_t  track = TRACK_CLEAR;

    logic in_took = 1'b0;
    logic calm;
    int   bytes_offered = 0;
    int   fixes_seen = 0;
    int   sentences_queued = 0;
    int   error_count = 0;
    int   quiet_cycles = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;

    nmea_gga_fix_quality_parser u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .char_in     (char_in),
        .end_of_line (end_of_line),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .fix_ok      (fix_ok),
        .fix_quality (fix_quality)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // no idling on either side while this window of bytes goes through
    assign calm = (bytes_offered >= 500) && (bytes_offered < 800);

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        error_count++;
    endtask

    // advance the sentence picture by one byte; queue a result on the final one
    task automatic predict_byte(input logic [7:0] c, input logic eol);
        logic        sep;
        logic        digit;
        logic        handled;
        logic [3:0]  nibble;
        fix_result_t r;
        if (!track.star)
        begin
            if (track.pos == 3'd0)
                track.dollar_ok = (c == CH_DOLLAR);
            else if (c == CH_STAR)
            begin
                track.star = 1'b1;
                if (track.pos < MIN_STAR_POS)
                    track.gga_ok = 1'b0;
            end
            else
            begin
                track.xsum ^= c;
                case (track.pos)
                    3'd3: track.gga_ok = (c == CH_G);
                    3'd4: track.gga_ok = track.gga_ok && (c == CH_G);
                    3'd5: track.gga_ok = track.gga_ok && (c == CH_A);
                    default: ;
                endcase
            end
            if (track.qstate == Q_OPEN)
            begin
                // the star closes the field being read
                sep = (c == CH_COMMA) || track.star;
                if (track.fld == QUALITY_FIELD)
                begin
                    if (sep)
                        track.qstate = (track.flen == 3'd0 || track.flen > MAX_FIELD_CHARS)
                                       ? Q_REJECT : Q_READ;
                    else if (track.flen <= MAX_FIELD_CHARS)
                    begin
                        track.flen++;
                        if (track.flen <= MAX_FIELD_CHARS)
                        begin
                            digit = (c >= CH_ZERO) && (c <= CH_NINE);
                            handled = 1'b0;
                            if (track.ph == PH_SKIP)
                            begin
                                if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
                                    handled = 1'b1;
                                else if (c == CH_PLUS || c == CH_MINUS)
                                begin
                                    track.neg = (c == CH_MINUS);
                                    track.ph = PH_DIGITS;
                                    handled = 1'b1;
                                end
                                else
                                    track.ph = digit ? PH_DIGITS : PH_STOP;
                            end
                            if (!handled && track.ph == PH_DIGITS)
                            begin
                                if (digit)
                                    track.val = 10'(track.val * 10'd10 + 10'(c - CH_ZERO));
                                else
                                    track.ph = PH_STOP;
                            end
                        end
                    end
                end
                else if (sep && track.fld < FIELD_SAT)
                    track.fld++;
            end
        end
        else if (track.hex_cnt < HEX_DIGITS)
        begin
            nibble = 4'd0;
            if (c >= CH_ZERO && c <= CH_NINE)
                nibble = 4'(c - CH_ZERO);
            else if (c >= CH_UA && c <= CH_UF)
                nibble = 4'(c - CH_UA + 8'd10);
            else if (c >= CH_LA && c <= CH_LF_A)
                nibble = 4'(c - CH_LA + 8'd10);
            else
                track.hex_good = 1'b0;
            if (track.hex_good)
                track.given_sum = {track.given_sum[3:0], nibble};
            track.hex_cnt++;
        end
        if (track.pos < POS_SAT)
            track.pos++;

        if (eol)
        begin
            r.ok = track.dollar_ok && track.gga_ok && track.star &&
                   track.hex_cnt == HEX_DIGITS && track.hex_good &&
                   track.xsum == track.given_sum && track.qstate == Q_READ;
            r.quality = '0;
            if (r.ok)
                r.quality = track.neg ? -$signed({1'b0, track.val})
                                      : $signed({1'b0, track.val});
            expected_fixes.push_back(r);
            track = TRACK_CLEAR;
        end
    endtask

    // ---- sentence construction ----

    function automatic logic [7:0] any_byte_but_sep();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_COMMA || b == CH_STAR);
        return b;
    endfunction

    function automatic logic [7:0] field_char();
        case ($urandom_range(0, 3))
            0: return CH_ZERO + 8'($urandom_range(0, 9));
            1: return 8'h2E;
            2: return CH_UA + 8'($urandom_range(0, 25));
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input logic lower);
        if (n < 4'd10)
            return CH_ZERO + 8'(n);
        return (lower ? CH_LA : CH_UA) + 8'(n) - 8'd10;
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            draft.push_back(s[i]);
    endtask

    task automatic add_junk_field();
        draft.push_back(CH_COMMA);
        repeat ($urandom_range(0, 3))
            draft.push_back(field_char());
    endtask

    // "$xxGGA" and five fields, up to the comma that opens the quality field
    task automatic start_gga();
        draft.delete();
        draft.push_back(CH_DOLLAR);
        repeat (2)
            draft.push_back(CH_UA + 8'($urandom_range(0, 25)));
        add_text("GGA");
        repeat (5)
            add_junk_field();
        draft.push_back(CH_COMMA);
    endtask

    task automatic finish_gga(input logic sum_good, input logic more_fields,
                              input logic lower);
        logic [7:0] sum;
        if (more_fields)
            repeat ($urandom_range(1, 4))
                add_junk_field();
        sum = 8'd0;
        for (int i = 1; i < draft.size(); i++)
            sum ^= draft[i];
        if (!sum_good)
            sum ^= 8'($urandom_range(1, 255));
        draft.push_back(CH_STAR);
        draft.push_back(hex_char(sum[7:4], lower));
        draft.push_back(hex_char(sum[3:0], lower));
    endtask

    task automatic add_random_quality();
        int len;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            len = 0;
        else if (roll < 20)
            len = $urandom_range(4, 6);
        else if (roll < 60)
            len = 1;
        else
            len = $urandom_range(2, 3);
        repeat (len)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
                draft.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            else if (roll < 70)
            begin
                roll = $urandom_range(0, 6);
                draft.push_back(roll == 6 ? CH_SPACE : CH_TAB + 8'(roll));
            end
            else if (roll < 80)
                draft.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            else
                draft.push_back(any_byte_but_sep());
        end
    endtask

    task automatic spoil_draft();
        int p;
        case ($urandom_range(0, 5))
            0: draft[$urandom_range(0, draft.size() - 1)] = 8'($urandom_range(0, 255));
            1: repeat ($urandom_range(1, 3))
                   if (draft.size() > 1)
                       void'(draft.pop_back());
            2: repeat ($urandom_range(1, 3))
                   draft.push_back(8'($urandom_range(0, 255)));
            3: draft[0] = $urandom_range(0, 1) ? CH_STAR : 8'($urandom_range(0, 255));
            4: draft.insert($urandom_range(1, 5), CH_STAR);
            default:
            begin
                p = $urandom_range(1, draft.size() - 4);
                draft.insert(p, CH_COMMA);
            end
        endcase
    endtask

    task automatic commit_draft();
        char_item_t it;
        for (int i = 0; i < draft.size(); i++)
        begin
            it.ch = draft[i];
            it.eol = (i == draft.size() - 1);
            pending_bytes.push_back(it);
        end
        sentences_queued++;
    endtask

    // ---- driver: one byte per transaction, new bytes at the falling edge ----
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_took)
        begin
            if (pending_bytes.size() == 0 || (!calm && $urandom_range(0, 99) < 16))
                in_valid <= 1'b0;
            else
            begin
                next_item = pending_bytes.pop_front();
                in_valid <= 1'b1;
                char_in <= next_item.ch;
                end_of_line <= next_item.eol;
                bytes_offered++;
            end
        end
    end

    // ---- receiver: random stall plus one long hold-off ----
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (!hold_done && fixes_seen >= 12)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !calm && ($urandom_range(0, 99) < 16);
    end

    // ---- monitor: predict on accepted bytes, check accepted results ----
    always @(posedge clk)
    begin
        if (!rst_n)
            in_took <= 1'b0;
        else
        begin
            in_took <= in_valid && !in_stall;
            if (in_valid && !in_stall)
                predict_byte(char_in, end_of_line);
            if (out_valid && !out_stall)
            begin
                fixes_seen++;
                if (expected_fixes.size() == 0)
                    report_mismatch($sformatf("unexpected result fix_ok=%0b fix_quality=%0d",
                                              fix_ok, fix_quality));
                else
                begin
                    want = expected_fixes.pop_front();
                    if (fix_ok !== want.ok)
                        report_mismatch($sformatf("fix_ok got %0b want %0b",
                                                  fix_ok, want.ok));
                    if (fix_quality !== want.quality)
                        report_mismatch($sformatf("fix_quality got %0d want %0d",
                                                  fix_quality, want.quality));
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        // directed sentences
        start_gga(); add_text("1");   finish_gga(1'b1, 1'b1, 1'b0); commit_draft();
        start_gga(); add_text("999"); finish_gga(1'b1, 1'b0, 1'b1); commit_draft();
        start_gga(); add_text("-99"); finish_gga(1'b1, 1'b1, 1'b0); commit_draft();
        start_gga();                  finish_gga(1'b1, 1'b1, 1'b0); commit_draft();
        start_gga(); add_text("1234"); finish_gga(1'b1, 1'b1, 1'b1); commit_draft();
        start_gga(); add_text(" +7"); finish_gga(1'b1, 1'b0, 1'b0); commit_draft();
        start_gga(); draft.push_back(CH_TAB); add_text("-5");
        finish_gga(1'b1, 1'b1, 1'b1); commit_draft();
        start_gga(); add_text("x");   finish_gga(1'b1, 1'b1, 1'b0); commit_draft();
        start_gga(); add_text("   "); finish_gga(1'b1, 1'b1, 1'b0); commit_draft();
        // bad checksum
        start_gga(); add_text("2");   finish_gga(1'b0, 1'b1, 1'b0); commit_draft();
        // star in place of the dollar
        start_gga(); add_text("2");   finish_gga(1'b1, 1'b1, 1'b0);
        draft[0] = CH_STAR; commit_draft();
        // a second star after the checksum
        start_gga(); add_text("1");   finish_gga(1'b1, 1'b1, 1'b1);
        add_text("*7F"); commit_draft();
        // trailing CR LF after the checksum
        start_gga(); add_text("4");   finish_gga(1'b1, 1'b0, 1'b0);
        draft.push_back(CH_CR); draft.push_back(CH_LF); commit_draft();
        // one checksum digit short
        start_gga(); add_text("1");   finish_gga(1'b1, 1'b1, 1'b0);
        void'(draft.pop_back()); commit_draft();
        // no star at all
        start_gga(); add_text("1,AB"); commit_draft();
        // wrong sentence type, checksum still right
        start_gga(); draft[5] = 8'h42; add_text("1"); finish_gga(1'b1, 1'b1, 1'b0);
        commit_draft();
        // star right after the type, and one byte too early
        draft.delete(); add_text("$GPGGA"); finish_gga(1'b1, 1'b0, 1'b0); commit_draft();
        draft.delete(); add_text("$GPGG");  finish_gga(1'b1, 1'b0, 1'b1); commit_draft();
        // non-hex byte after the star
        start_gga(); add_text("3");   finish_gga(1'b1, 1'b1, 1'b0);
        draft[draft.size() - 2] = CH_G; commit_draft();
        // single-byte sentence and raw extremes
        draft.delete(); draft.push_back(CH_DOLLAR); commit_draft();
        draft.delete(); draft.push_back(8'h00); draft.push_back(8'hFF);
        draft.push_back(8'h80); commit_draft();

        // random: mostly well-formed sentences, some spoilt, some noise
        while (pending_bytes.size() < 1600 || sentences_queued < 80)
        begin
            if ($urandom_range(0, 99) < 12)
            begin
                draft.delete();
                repeat ($urandom_range(1, 12))
                    draft.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                start_gga();
                add_random_quality();
                finish_gga($urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
                if ($urandom_range(0, 99) < 20)
                    spoil_draft();
            end
            commit_draft();
        end

        repeat (10) @(posedge clk);
        #2 rst_n = 1'b1;

        while (pending_bytes.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_fixes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
